>>> design/chs_pkg.sv
// Shared types, constants and arithmetic helpers for the cosine hemisphere sampler.
// No dependencies; chs_sine, chs_norm and the top module import this package.
package chs_pkg;

    // Internal fixed point: signed Q30 with headroom for non-unit normals
    localparam int VW = 36;

    typedef logic signed [VW-1:0] t_q;
    typedef logic [VW-1:0]        t_mag;
    typedef logic [2:0][VW-1:0]   t_vec;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

    localparam t_q ONE30  = t_q'(64'd1 << 30);
    localparam t_q SIN_C0 = t_q'(64'sd1686629713);
    localparam t_q SIN_C1 = t_q'(-64'sd693598668);
    localparam t_q SIN_C2 = t_q'(64'sd85569306);
    localparam t_q SIN_C3 = t_q'(-64'sd5026995);
    localparam t_q SIN_C4 = t_q'(64'sd172272);

    // 0.999 threshold, scaled by 1000 against Q30 magnitudes
    localparam logic [47:0] AXIS_LIMIT = 48'd999 << 30;
    // 1/pi in Q32
    localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;

    // Square root and divider geometry of the normalizer
    localparam int SQ_IW  = 62;
    localparam int SQ_OW  = 31;
    localparam int DIV_NW = 61;
    localparam int DIV_DW = 31;
    localparam int DIV_QW = 31;

    localparam int SINE_LAT = 6;
    localparam int NORM_LAT = 69;

    function automatic t_mag mag(input t_q v);
        return v[VW-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    // (a*b) >> 30, rounded half away from zero
    function automatic t_q mul_q30(input t_q a, input t_q b);
        logic [2*VW-1:0] p;
        p = (2*VW)'(mag(a)) * (2*VW)'(mag(b)) + ((2*VW)'(1) << 29);
        return (a[VW-1] ^ b[VW-1]) ? -t_q'(p[VW+29:30]) : t_q'(p[VW+29:30]);
    endfunction

    // Length at most 1e-8: every magnitude below 256 and sum of squares at most 115
    function automatic logic is_tiny(input t_vec v);
        t_mag        m;
        logic        all_low;
        logic [17:0] sum;
        all_low = 1'b1;
        sum     = '0;
        for (int i = 0; i < 3; i++) begin
            m = mag(t_q'(v[i]));
            if (m >= t_mag'(256)) begin
                all_low = 1'b0;
            end
            sum = sum + 18'(m[7:0]) * 18'(m[7:0]);
        end
        return all_low && (sum <= 18'd115);
    endfunction

    function automatic logic [5:0] msb_pos(input t_mag m);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < VW; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> design/chs_if.sv
// Request and response channel interfaces of the hemisphere sampler.
// Standalone; widths follow the component and fraction width parameters.
interface chs_req_if #(
    parameter int CW = 16,
    parameter int RW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
    logic [RW-1:0]        rand_u;
    logic [RW-1:0]        rand_v;

    modport source (output valid, normal_x, normal_y, normal_z, rand_u, rand_v, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, rand_u, rand_v, output ready);
endinterface

interface chs_rsp_if #(
    parameter int CW = 16,
    parameter int RW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic [RW-1:0]        density;

    modport source (output valid, dir_x, dir_y, dir_z, density, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, density, output ready);
endinterface

>>> design/chs_delay.sv
// Enable-gated delay line for side data that travels alongside the pipeline.
// No dependencies.
module chs_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_pipe [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_d = r_pipe[D-1];
endmodule

>>> design/chs_isqrt.sv
// Pipelined floor square root, one result bit per stage (restoring).
// No dependencies; the stages advance only on enabled cycles.
module chs_isqrt #(
    parameter int IW = 62
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_x,
    output logic [IW/2-1:0] o_root
);
    localparam int OW = IW / 2;

    logic [OW+1:0] r_rem  [OW];
    logic [OW-1:0] r_root [OW];
    logic [IW-1:0] r_x    [OW];

    for (genvar s = 0; s < OW; s++) begin : g_stage
        logic [OW+1:0] rem_prev;
        logic [OW-1:0] root_prev;
        logic [IW-1:0] x_prev;
        logic [OW+1:0] rem_sh;
        logic [OW+1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign x_prev    = i_x;
        end else begin : g_next
            assign rem_prev  = r_rem[s-1];
            assign root_prev = r_root[s-1];
            assign x_prev    = r_x[s-1];
        end

        // remainder stays below 2^OW until the last step
        assign rem_sh = {rem_prev[OW-1:0], x_prev[IW-1:IW-2]};
        assign trial  = {root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? rem_sh - trial : rem_sh;
                r_root[s] <= {root_prev[OW-2:0], ge};
                r_x[s]    <= {x_prev[IW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[OW-1];
endmodule

>>> design/chs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// No dependencies; needs num >> QW below den; the stages advance only on enabled cycles.
module chs_div #(
    parameter int NW = 61,
    parameter int DW = 31,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [QW-1:0] lo_prev;
        logic [QW-1:0] quo_prev;
        logic [DW-1:0] den_prev;
        logic [DW:0]   rem_sh;
        logic [DW:0]   diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_prev = DW'(i_num[NW-1:QW]);
            assign lo_prev  = i_num[QW-1:0];
            assign quo_prev = '0;
            assign den_prev = i_den;
        end else begin : g_next
            assign rem_prev = r_rem[s-1];
            assign lo_prev  = r_lo[s-1];
            assign quo_prev = r_quo[s-1];
            assign den_prev = r_den[s-1];
        end

        assign rem_sh = {rem_prev, lo_prev[QW-1]};
        assign ge     = rem_sh >= {1'b0, den_prev};
        assign diff   = rem_sh - {1'b0, den_prev};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_lo[s]  <= {lo_prev[QW-2:0], 1'b0};
                r_quo[s] <= {quo_prev[QW-2:0], ge};
                r_den[s] <= den_prev;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

>>> design/chs_sine.sv
// Quarter-turn sine, odd polynomial by Horner's rule, one multiply per stage.
// Depends on chs_pkg; the stages advance only on enabled cycles.
module chs_sine (
    input  logic          i_clk,
    input  logic          i_en,
    input  chs_pkg::t_q   i_t,
    output chs_pkg::t_q   o_p
);
    import chs_pkg::*;

    t_q r_ta, r_tb, r_tc, r_td, r_te;
    t_q r_t2a, r_t2b, r_t2c, r_t2d;
    t_q r_pb, r_pc, r_pd, r_pe, r_p;
    t_q w_last;

    assign w_last = mul_q30(r_pe, r_te);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ta  <= i_t;
            r_t2a <= mul_q30(i_t, i_t);
            r_tb  <= r_ta;
            r_t2b <= r_t2a;
            r_pb  <= SIN_C3 + mul_q30(SIN_C4, r_t2a);
            r_tc  <= r_tb;
            r_t2c <= r_t2b;
            r_pc  <= SIN_C2 + mul_q30(r_pb, r_t2b);
            r_td  <= r_tc;
            r_t2d <= r_t2c;
            r_pd  <= SIN_C1 + mul_q30(r_pc, r_t2c);
            r_te  <= r_td;
            r_pe  <= SIN_C0 + mul_q30(r_pd, r_t2d);
            if (w_last < 0) begin
                r_p <= '0;
            end else if (w_last > ONE30) begin
                r_p <= ONE30;
            end else begin
                r_p <= w_last;
            end
        end
    end

    assign o_p = r_p;
endmodule

>>> design/chs_norm.sv
// Vector normalizer: range scaling, sum of squares, square root, three dividers.
// Depends on chs_pkg, chs_delay, chs_isqrt, chs_div; the stages advance only on enabled cycles.
module chs_norm (
    input  logic          i_clk,
    input  logic          i_en,
    input  chs_pkg::t_vec i_vec,
    output chs_pkg::t_vec o_vec
);
    import chs_pkg::*;

    t_vec              r1_v, r2_v;
    t_mag              r1_m [3];
    t_mag              r2_m [3];
    t_mag              r3_m [3];
    t_mag              w_mx;
    t_mag              r2_mx;
    logic              r2_deg;
    logic              r3_right;
    logic [5:0]        r3_sh;
    logic [5:0]        w_pos;
    logic [29:0]       r4_a [3];
    logic [59:0]       r5_sq [3];
    logic [SQ_IW-1:0]  r6_sum;
    logic [SQ_OW-1:0]  w_len;
    logic [89:0]       w_a;
    logic [3*VW:0]     w_vd;
    logic [DIV_QW-1:0] w_q [3];
    t_vec              w_v;
    logic              w_deg;
    t_vec              r_out;

    always_comb begin
        w_mx = r1_m[0];
        if (r1_m[1] > w_mx) begin
            w_mx = r1_m[1];
        end
        if (r1_m[2] > w_mx) begin
            w_mx = r1_m[2];
        end
    end

    assign w_pos = msb_pos(r2_mx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v <= i_vec;
            for (int i = 0; i < 3; i++) begin
                r1_m[i] <= mag(t_q'(i_vec[i]));
            end
            r2_v   <= r1_v;
            r2_m   <= r1_m;
            r2_mx  <= w_mx;
            r2_deg <= is_tiny(r1_v);
            r3_m   <= r2_m;
            // bring the largest magnitude into [2^29, 2^30)
            if (w_pos >= 6'd30) begin
                r3_right <= 1'b1;
                r3_sh    <= w_pos - 6'd29;
            end else begin
                r3_right <= 1'b0;
                r3_sh    <= 6'd29 - w_pos;
            end
            for (int i = 0; i < 3; i++) begin
                r4_a[i]  <= r3_right ? 30'(r3_m[i] >> r3_sh) : 30'(r3_m[i] << r3_sh);
                r5_sq[i] <= 60'(r4_a[i]) * 60'(r4_a[i]);
            end
            r6_sum <= SQ_IW'(r5_sq[0]) + SQ_IW'(r5_sq[1]) + SQ_IW'(r5_sq[2]);
        end
    end

    chs_isqrt #(.IW(SQ_IW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r6_sum),
        .o_root (w_len)
    );

    chs_delay #(.W(90), .D(33)) u_dly_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r4_a[2], r4_a[1], r4_a[0]}),
        .o_d   (w_a)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [DIV_NW-1:0] num;
        // rounded quotient: (a << 30 + len/2) / len
        assign num = {1'b0, w_a[30*i +: 30], 30'b0} + DIV_NW'(w_len >> 1);
        chs_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (num),
            .i_den (w_len),
            .o_quo (w_q[i])
        );
    end

    chs_delay #(.W(3*VW+1), .D(66)) u_dly_v (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r2_deg, r2_v}),
        .o_d   (w_vd)
    );

    assign w_deg = w_vd[3*VW];
    assign w_v   = w_vd[3*VW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_deg) begin
                    r_out[i] <= w_v[i];
                end else begin
                    r_out[i] <= w_v[i][VW-1] ? -t_q'(w_q[i]) : t_q'(w_q[i]);
                end
            end
        end
    end

    assign o_vec = r_out;
endmodule

>>> design/cosine_hemisphere_sampler_top.sv
// Cosine-weighted hemisphere sampler: normal plus two random fractions in, direction and
// density out. Depends on chs_pkg, chs_if, chs_delay, chs_isqrt, chs_sine, chs_norm.
//
// Fully pipelined: one request is taken every clock while the output is not stalled. The
// pipeline runs through three normalizers in series (tangent, bitangent, sample), each
// built from a square root and three dividers that resolve one bit per stage. A stalled
// output freezes the whole pipeline in place; ready drops only while a finished result is
// waiting and the consumer is not taking it. There is no state and no configuration, and
// the block is usable right after reset.
module cosine_hemisphere_sampler_top #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int RANDOM_WIDTH    = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chs_req_if.sink   i_req,
    chs_rsp_if.source o_rsp
);
    import chs_pkg::*;

    localparam int CW   = COMPONENT_WIDTH;
    localparam int RW   = RANDOM_WIDTH;
    localparam int NSH  = 32 - CW;
    localparam int L_R  = 1 + SQ_OW;
    localparam int L_T  = 3 + NORM_LAT;
    localparam int L_B  = L_T + 2 + NORM_LAT;
    localparam int L_S  = L_B + 2 + NORM_LAT;
    localparam int LAT  = L_S + 2;
    localparam logic [63:0] DEN_TINY = (64'd1 << RW) / 64'd10000000;
    localparam logic [36:0] RND      = 37'((64'd1 << NSH) >> 1);
    localparam logic signed [37:0] LIM_HI = 38'sd1 <<< (CW - 1);

    logic         w_en;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // ---- stage 1: input capture
    t_vec          r_n1;
    logic [RW-1:0] r_u1, r_v1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1[0] <= t_q'(i_req.normal_x) <<< NSH;
            r_n1[1] <= t_q'(i_req.normal_y) <<< NSH;
            r_n1[2] <= t_q'(i_req.normal_z) <<< NSH;
            r_u1    <= i_req.rand_u;
            r_v1    <= i_req.rand_v;
        end
    end

    // ---- disk radius and height
    logic [SQ_IW-1:0] w_arg_r, w_arg_z;
    logic [SQ_OW-1:0] w_r32, w_z32;

    assign w_arg_r = SQ_IW'(r_u1) << (60 - RW);
    assign w_arg_z = ((SQ_IW'(1) << RW) - SQ_IW'(r_u1)) << (60 - RW);

    chs_isqrt #(.IW(SQ_IW)) u_sqrt_r (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_arg_r), .o_root (w_r32)
    );
    chs_isqrt #(.IW(SQ_IW)) u_sqrt_z (
        .i_clk (i_clk), .i_en (w_en), .i_x (w_arg_z), .o_root (w_z32)
    );

    // ---- angle
    t_q         w_tq, w_tqc, w_s7, w_c7;
    logic [1:0] w_quad7;
    t_q         r_sn8, r_cs8;
    logic [2*VW-1:0] w_sc32;

    assign w_tq  = t_q'(r_v1[RW-3:0]) <<< (32 - RW);
    assign w_tqc = ONE30 - w_tq;

    chs_sine u_sine_s (.i_clk (i_clk), .i_en (w_en), .i_t (w_tq),  .o_p (w_s7));
    chs_sine u_sine_c (.i_clk (i_clk), .i_en (w_en), .i_t (w_tqc), .o_p (w_c7));

    chs_delay #(.W(2), .D(SINE_LAT)) u_dly_quad (
        .i_clk (i_clk), .i_en (w_en), .i_d (r_v1[RW-1:RW-2]), .o_d (w_quad7)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            case (t_quad'(w_quad7))
                QUAD_0: begin
                    r_sn8 <= w_s7;
                    r_cs8 <= w_c7;
                end
                QUAD_1: begin
                    r_sn8 <= w_c7;
                    r_cs8 <= -w_s7;
                end
                QUAD_2: begin
                    r_sn8 <= -w_s7;
                    r_cs8 <= -w_c7;
                end
                default: begin
                    r_sn8 <= -w_c7;
                    r_cs8 <= w_s7;
                end
            endcase
        end
    end

    chs_delay #(.W(2*VW), .D(L_R - SINE_LAT - 2)) u_dly_sc (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r_sn8, r_cs8}), .o_d (w_sc32)
    );

    // ---- disk point and density
    t_q            r_x33, r_y33, r_z33;
    logic [RW-1:0] r_den33;
    logic          r_big33;
    logic [63:0]   w_dprod, w_dens;

    assign w_dprod = 64'(w_z32) * INV_PI_Q32 + (64'd1 << (61 - RW));
    assign w_dens  = w_dprod >> (62 - RW);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x33   <= mul_q30(t_q'(w_r32), t_q'(w_sc32[VW-1:0]));
            r_y33   <= mul_q30(t_q'(w_r32), t_q'(w_sc32[2*VW-1:VW]));
            r_z33   <= t_q'(w_z32);
            r_den33 <= RW'(w_dens);
            r_big33 <= w_dens > DEN_TINY;
        end
    end

    // ---- tangent: both helper-axis candidates, fallback when the first is degenerate
    t_vec r_ta2, r_tb2, r_tsel3, w_tn;
    t_q   w_nx1, w_ny1, w_nz1;

    assign w_nx1 = t_q'(r_n1[0]);
    assign w_ny1 = t_q'(r_n1[1]);
    assign w_nz1 = t_q'(r_n1[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (48'(mag(w_nz1)) * 48'd1000 < AXIS_LIMIT) begin
                r_ta2 <= {t_q'(0), -w_nx1, w_ny1};
            end else begin
                r_ta2 <= {-w_ny1, w_nz1, t_q'(0)};
            end
            if (48'(mag(w_nx1)) * 48'd1000 > AXIS_LIMIT) begin
                r_tb2 <= {-w_nx1, t_q'(0), w_nz1};
            end else begin
                r_tb2 <= {w_ny1, -w_nz1, t_q'(0)};
            end
            r_tsel3 <= is_tiny(r_ta2) ? r_tb2 : r_ta2;
        end
    end

    chs_norm u_norm_t (.i_clk (i_clk), .i_en (w_en), .i_vec (r_tsel3), .o_vec (w_tn));

    // ---- bitangent B = N x T
    t_vec w_n72;
    t_q   r_bp [6];
    t_vec r_b74, w_bn;

    chs_delay #(.W(3*VW), .D(L_T - 1)) u_dly_n72 (
        .i_clk (i_clk), .i_en (w_en), .i_d (r_n1), .o_d (w_n72)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bp[0] <= mul_q30(t_q'(w_n72[1]), t_q'(w_tn[2]));
            r_bp[1] <= mul_q30(t_q'(w_n72[2]), t_q'(w_tn[1]));
            r_bp[2] <= mul_q30(t_q'(w_n72[2]), t_q'(w_tn[0]));
            r_bp[3] <= mul_q30(t_q'(w_n72[0]), t_q'(w_tn[2]));
            r_bp[4] <= mul_q30(t_q'(w_n72[0]), t_q'(w_tn[1]));
            r_bp[5] <= mul_q30(t_q'(w_n72[1]), t_q'(w_tn[0]));
            r_b74[0] <= r_bp[0] - r_bp[1];
            r_b74[1] <= r_bp[2] - r_bp[3];
            r_b74[2] <= r_bp[4] - r_bp[5];
        end
    end

    chs_norm u_norm_b (.i_clk (i_clk), .i_en (w_en), .i_vec (r_b74), .o_vec (w_bn));

    // ---- world sample T*x + B*y + N*z
    t_vec            w_tn143, w_n143, r_smp;
    logic [3*VW-1:0] w_xyz143;
    t_q              r_sp [3][3];
    t_vec            w_dir;

    chs_delay #(.W(3*VW), .D(L_B - L_T)) u_dly_tn (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_tn), .o_d (w_tn143)
    );
    chs_delay #(.W(3*VW), .D(L_B - L_T)) u_dly_n143 (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_n72), .o_d (w_n143)
    );
    chs_delay #(.W(3*VW), .D(L_B - 33)) u_dly_xyz (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r_z33, r_y33, r_x33}), .o_d (w_xyz143)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sp[i][0] <= mul_q30(t_q'(w_tn143[i]), t_q'(w_xyz143[VW-1:0]));
                r_sp[i][1] <= mul_q30(t_q'(w_bn[i]), t_q'(w_xyz143[2*VW-1:VW]));
                r_sp[i][2] <= mul_q30(t_q'(w_n143[i]), t_q'(w_xyz143[3*VW-1:2*VW]));
                r_smp[i]   <= r_sp[i][0] + r_sp[i][1] + r_sp[i][2];
            end
        end
    end

    chs_norm u_norm_s (.i_clk (i_clk), .i_en (w_en), .i_vec (r_smp), .o_vec (w_dir));

    // ---- surface test, rounding and saturation
    t_vec                 w_n214, r_dir215;
    logic signed [63:0]   r_dp [3];
    logic signed [63:0]   w_dot;
    logic [RW:0]          w_den215;
    logic signed [37:0]   w_q [3];
    logic [36:0]          w_mr [3];
    logic [CW-1:0]        r_out [3];
    logic [RW-1:0]        r_dens;

    chs_delay #(.W(3*VW), .D(L_S - L_B)) u_dly_n214 (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_n143), .o_d (w_n214)
    );
    chs_delay #(.W(RW+1), .D(L_S + 1 - 33)) u_dly_den (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r_big33, r_den33}), .o_d (w_den215)
    );

    assign w_dot = r_dp[0] + r_dp[1] + r_dp[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // round half away from zero on the magnitude
            w_mr[i] = (37'(mag(t_q'(r_dir215[i]))) + RND) >> NSH;
            w_q[i]  = r_dir215[i][VW-1] ? -38'(w_mr[i]) : 38'(w_mr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dir215 <= w_dir;
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= 64'(t_q'(w_n214[i])) * 64'(t_q'(w_dir[i]));
                if (w_q[i] > LIM_HI - 38'sd1) begin
                    r_out[i] <= CW'(LIM_HI - 38'sd1);
                end else if (w_q[i] < -LIM_HI) begin
                    r_out[i] <= CW'(-LIM_HI);
                end else begin
                    r_out[i] <= CW'(w_q[i]);
                end
            end
            // direction below the surface with a non-negligible density
            r_dens <= (w_dot < 0 && w_den215[RW]) ? '0 : w_den215[RW-1:0];
        end
    end

    assign o_rsp.valid   = r_vld[LAT-1];
    assign o_rsp.dir_x   = r_out[0];
    assign o_rsp.dir_y   = r_out[1];
    assign o_rsp.dir_z   = r_out[2];
    assign o_rsp.density = r_dens;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAT-1] |-> i_req.ready)
        else $error("request refused with an empty output stage");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request not tracked in first stage");
endmodule
